[design/spot_pattern_model_eval_unit_defines.svh]
// assertion macros for the spot pattern model evaluator
`ifndef SPOT_PATTERN_MODEL_EVAL_UNIT_DEFINES_SVH
`define SPOT_PATTERN_MODEL_EVAL_UNIT_DEFINES_SVH

// same-cycle implication
`define SPME_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spme_pkg.sv]
// shared constants and types of the spot pattern model evaluator
package spme_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int N_SIDE  = 4;
  localparam int N_CELLS = 16;
  localparam int SUM_W   = 21;
  localparam int CNT_W   = 5;
  localparam int OFS_W   = 35;
  localparam int QDEPTH  = 256;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd6;

  localparam logic signed [31:0] STEP_X_RST = 32'sd1179648;
  localparam logic signed [31:0] STEP_Y_RST = 32'sd1572864;

  localparam logic signed [33:0] DEG90  = 34'sd5898240;
  localparam logic signed [33:0] DEG180 = 34'sd11796480;
  localparam logic signed [33:0] DEG360 = 34'sd23592960;

  localparam logic signed [34:0] KRAD  = 35'sd18740330;
  localparam logic signed [34:0] COEF1 = 35'sd1073414225;
  localparam logic signed [34:0] COEF3 = 35'sd177886808;
  localparam logic signed [34:0] COEF5 = 35'sd8067452;

  localparam int CAP_AXIS = 786432;
  localparam logic [40:0] CAP_SQ    = 41'd618475290624;
  localparam logic [29:0] RECIP9    = 30'd954437177;
  localparam logic [31:0] Y_ONE     = 32'h8000_0000;
  localparam logic [63:0] SQ_HALF   = 64'h0000_0000_4000_0000;
  localparam logic [32:0] TERM_HALF = 33'h0_0000_4000;
  localparam logic [SUM_W-1:0] MODEL_MAX = 21'd1048576;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } acc_t;

endpackage

[design/spme_setup.sv]
// configuration registers and the sequencer that derives the spot offsets
module spme_setup (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [spme_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [63:0]                            cfg_data,
  output logic                                   busy,
  output logic signed [spme_pkg::OFS_W-1:0]      ox [spme_pkg::N_CELLS],
  output logic signed [spme_pkg::OFS_W-1:0]      oy [spme_pkg::N_CELLS]
);

  localparam logic [4:0] ST_LOAD      = 5'd0;
  localparam logic [4:0] ST_MOD_FIRST = 5'd1;
  localparam logic [4:0] ST_MOD_LAST  = 5'd7;
  localparam logic [4:0] ST_FOLD      = 5'd8;
  localparam logic [4:0] ST_X         = 5'd9;
  localparam logic [4:0] ST_X2        = 5'd10;
  localparam logic [4:0] ST_X3        = 5'd11;
  localparam logic [4:0] ST_X5        = 5'd12;
  localparam logic [4:0] ST_T1        = 5'd13;
  localparam logic [4:0] ST_T3        = 5'd14;
  localparam logic [4:0] ST_T5        = 5'd15;
  localparam logic [4:0] ST_SUM       = 5'd16;
  localparam logic [4:0] ST_A         = 5'd17;
  localparam logic [4:0] ST_B         = 5'd18;
  localparam logic [4:0] ST_E         = 5'd19;
  localparam logic [4:0] ST_D         = 5'd20;
  localparam logic [4:0] ST_DLAST     = 5'd21;
  localparam logic [4:0] ST_DIODE     = 5'd22;
  localparam logic [4:0] ST_OFS       = 5'd23;

  logic [63:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [31:0] ang, sx, sy;

  logic [4:0] step;
  logic phase, vneg, sneg;
  logic [33:0] r;
  logic [22:0] mag;
  logic [30:0] x;
  logic [31:0] x2, x3, t1, t3;
  logic [33:0] x5;
  logic signed [31:0] sin_s, cos_c;
  logic signed [69:0] prod;
  logic signed [63:0] pa, pb, pe, pd;
  logic signed [33:0] xd [spme_pkg::N_SIDE];
  logic signed [33:0] yd [spme_pkg::N_SIDE];
  logic signed [33:0] xs [spme_pkg::N_SIDE];
  logic signed [33:0] ys [spme_pkg::N_SIDE];

  logic signed [33:0] v, vabs, mod_sub, rr, rr2, fold, fold_abs, s34, sres;
  logic signed [34:0] ma, mb;
  logic [2:0] mod_k;
  logic is_mod;
  logic signed [33:0] tx [spme_pkg::N_SIDE];
  logic signed [33:0] ty [spme_pkg::N_SIDE];
  logic signed [33:0] xs_c [spme_pkg::N_SIDE];
  logic signed [33:0] ys_c [spme_pkg::N_SIDE];
  logic signed [64:0] ea, eb, ee, ed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lo <= '0;
      x_hi <= '0;
      y_lo <= '0;
      y_hi <= '0;
      ang  <= '0;
      sx   <= spme_pkg::STEP_X_RST;
      sy   <= spme_pkg::STEP_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spme_pkg::REG_X_LO:   x_lo <= cfg_data;
        spme_pkg::REG_X_HI:   x_hi <= cfg_data;
        spme_pkg::REG_Y_LO:   y_lo <= cfg_data;
        spme_pkg::REG_Y_HI:   y_hi <= cfg_data;
        spme_pkg::REG_ANGLE:  ang  <= cfg_data[31:0];
        spme_pkg::REG_STEP_X: sx   <= cfg_data[31:0];
        spme_pkg::REG_STEP_Y: sy   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    v = {{2{ang[31]}}, ang} + (phase ? spme_pkg::DEG90 : 34'sd0);
    vabs = v[33] ? -v : v;
    mod_k = 3'd7 - step[2:0];
    mod_sub = spme_pkg::DEG360 <<< mod_k;
    is_mod = (step >= ST_MOD_FIRST) && (step <= ST_MOD_LAST);
    rr = (vneg && (r != 34'd0)) ? spme_pkg::DEG360 - $signed(r) : $signed(r);
    rr2 = (rr >= spme_pkg::DEG180) ? rr - spme_pkg::DEG360 : rr;
    if (rr2 > spme_pkg::DEG90) begin
      fold = spme_pkg::DEG180 - rr2;
    end else if (rr2 < -spme_pkg::DEG90) begin
      fold = -spme_pkg::DEG180 - rr2;
    end else begin
      fold = rr2;
    end
    fold_abs = fold[33] ? -fold : fold;
    s34 = $signed({2'b00, t1}) - $signed({2'b00, t3}) + $signed({1'b0, prod[62:30]});
    sres = sneg ? -s34 : s34;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      ST_X: begin
        ma = $signed({12'd0, mag});
        mb = spme_pkg::KRAD;
      end
      ST_X2: begin
        ma = $signed({4'd0, prod[46:16]});
        mb = $signed({4'd0, prod[46:16]});
      end
      ST_X3: begin
        ma = $signed({3'd0, prod[61:30]});
        mb = $signed({4'd0, x});
      end
      ST_X5: begin
        ma = $signed({3'd0, prod[61:30]});
        mb = $signed({3'd0, x2});
      end
      ST_T1: begin
        ma = spme_pkg::COEF1;
        mb = $signed({4'd0, x});
      end
      ST_T3: begin
        ma = spme_pkg::COEF3;
        mb = $signed({3'd0, x3});
      end
      ST_T5: begin
        ma = spme_pkg::COEF5;
        mb = $signed({1'b0, x5});
      end
      ST_A: begin
        ma = {{3{cos_c[31]}}, cos_c};
        mb = {{3{sx[31]}}, sx};
      end
      ST_B: begin
        ma = {{3{sin_s[31]}}, sin_s};
        mb = {{3{sy[31]}}, sy};
      end
      ST_E: begin
        ma = {{3{cos_c[31]}}, cos_c};
        mb = {{3{sy[31]}}, sy};
      end
      ST_D: begin
        ma = {{3{sin_s[31]}}, sin_s};
        mb = {{3{sx[31]}}, sx};
      end
      default: ;
    endcase
  end

  always_comb begin
    tx[0] = {{2{x_lo[31]}}, x_lo[31:0]};
    tx[1] = {{2{x_lo[63]}}, x_lo[63:32]};
    tx[2] = {{2{x_hi[31]}}, x_hi[31:0]};
    tx[3] = {{2{x_hi[63]}}, x_hi[63:32]};
    ty[0] = {{2{y_lo[31]}}, y_lo[31:0]};
    ty[1] = {{2{y_lo[63]}}, y_lo[63:32]};
    ty[2] = {{2{y_hi[31]}}, y_hi[31:0]};
    ty[3] = {{2{y_hi[63]}}, y_hi[63:32]};
    xs_c[0] = tx[0] + tx[1] + tx[2] + tx[3];
    xs_c[1] = tx[0] - tx[1] + tx[2] - tx[3];
    xs_c[2] = tx[0] + tx[1] - tx[2] - tx[3];
    xs_c[3] = tx[0] - tx[1] - tx[2] + tx[3];
    ys_c[0] = ty[0] + ty[1] + ty[2] + ty[3];
    ys_c[1] = ty[0] - ty[1] + ty[2] - ty[3];
    ys_c[2] = ty[0] + ty[1] - ty[2] - ty[3];
    ys_c[3] = ty[0] - ty[1] - ty[2] + ty[3];
    ea = {pa[63], pa};
    eb = {pb[63], pb};
    ee = {pe[63], pe};
    ed = {pd[63], pd};
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      step  <= ST_LOAD;
      phase <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      busy  <= 1'b1;
      step  <= ST_LOAD;
      phase <= 1'b0;
    end else if (busy) begin
      case (step)
        ST_LOAD: begin
          vneg <= v[33];
          r    <= vabs;
          step <= ST_MOD_FIRST;
        end
        ST_FOLD: begin
          mag  <= fold_abs[22:0];
          sneg <= fold[33];
          step <= ST_X;
        end
        ST_X: step <= ST_X2;
        ST_X2: begin
          x    <= prod[46:16];
          step <= ST_X3;
        end
        ST_X3: begin
          x2   <= prod[61:30];
          step <= ST_X5;
        end
        ST_X5: begin
          x3   <= prod[61:30];
          step <= ST_T1;
        end
        ST_T1: begin
          x5   <= prod[63:30];
          step <= ST_T3;
        end
        ST_T3: begin
          t1   <= prod[61:30];
          step <= ST_T5;
        end
        ST_T5: begin
          t3   <= prod[61:30];
          step <= ST_SUM;
        end
        ST_SUM: begin
          if (!phase) begin
            sin_s <= sres[31:0];
            phase <= 1'b1;
            step  <= ST_LOAD;
          end else begin
            cos_c <= sres[31:0];
            step  <= ST_A;
          end
        end
        ST_A: step <= ST_B;
        ST_B: begin
          pa   <= prod[63:0];
          step <= ST_E;
        end
        ST_E: begin
          pb   <= prod[63:0];
          step <= ST_D;
        end
        ST_D: begin
          pe   <= prod[63:0];
          step <= ST_DLAST;
        end
        ST_DLAST: begin
          pd   <= prod[63:0];
          step <= ST_DIODE;
        end
        ST_DIODE: begin
          xd[0] <= 34'((-ea + eb) >>> 31);
          xd[1] <= 34'((-ea - eb) >>> 31);
          xd[2] <= 34'((ea - eb) >>> 31);
          xd[3] <= 34'((ea + eb) >>> 31);
          yd[0] <= 34'((ee + ed) >>> 31);
          yd[1] <= 34'((-ee + ed) >>> 31);
          yd[2] <= 34'((-ee - ed) >>> 31);
          yd[3] <= 34'((ee - ed) >>> 31);
          for (int k = 0; k < spme_pkg::N_SIDE; k++) begin
            xs[k] <= xs_c[k];
            ys[k] <= ys_c[k];
          end
          step <= ST_OFS;
        end
        ST_OFS: begin
          for (int i = 0; i < spme_pkg::N_SIDE; i++) begin
            for (int j = 0; j < spme_pkg::N_SIDE; j++) begin
              ox[i*spme_pkg::N_SIDE + j] <= {xs[j][33], xs[j]} + {xd[i][33], xd[i]};
              oy[i*spme_pkg::N_SIDE + j] <= {ys[j][33], ys[j]} + {yd[i][33], yd[i]};
            end
          end
          busy <= 1'b0;
        end
        default: begin
          if (is_mod) begin
            if ($signed(r) >= mod_sub) begin
              r <= r - mod_sub;
            end
            step <= step + 5'd1;
          end else begin
            step <= ST_LOAD;
          end
        end
      endcase
    end
  end

endmodule

[design/spme_cell.sv]
// one spot cell: distance, capture test and term, added onto the passing sum
module spme_cell #(
  parameter int COORD_BITS = spme_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spme_pkg::acc_t                    acc_in,
  input  logic [COORD_BITS-1:0]             px_in,
  input  logic [COORD_BITS-1:0]             py_in,
  input  logic signed [spme_pkg::OFS_W-1:0] ox,
  input  logic signed [spme_pkg::OFS_W-1:0] oy,
  output spme_pkg::acc_t                    acc_out,
  output logic [COORD_BITS-1:0]             px_out,
  output logic [COORD_BITS-1:0]             py_out
);

  localparam int PX_W = COORD_BITS + 16;
  localparam int FX_W = ((PX_W > 34) ? PX_W : 34) + 2;
  localparam int DLY  = 14;
  localparam int NSQ  = 8;
  localparam logic signed [FX_W-1:0] CAP_F = FX_W'(spme_pkg::CAP_AXIS);

  spme_pkg::acc_t acc_d [DLY];
  logic [COORD_BITS-1:0] pxd [DLY];
  logic [COORD_BITS-1:0] pyd [DLY];

  logic signed [FX_W-1:0] fx1, fy1, fxa, fya, fx_c, fy_c;
  logic inr2, inr3, hit4, hit5, hit6;
  logic [19:0] ax2, ay2;
  logic [39:0] axx3, ayy3;
  logic [40:0] q4;
  logic [28:0] n4;
  logic [58:0] p5;
  logic [31:0] y6;
  logic [31:0] sq [NSQ];
  logic        hsq [NSQ];
  logic [63:0] sq_p [NSQ];
  logic [32:0] term_r;
  logic [16:0] term;

  always_comb begin
    fx_c = $signed({{(FX_W-PX_W){1'b0}}, px_in, 16'd0})
         - $signed({{(FX_W-spme_pkg::OFS_W){ox[spme_pkg::OFS_W-1]}}, ox});
    fy_c = $signed({{(FX_W-PX_W){1'b0}}, py_in, 16'd0})
         - $signed({{(FX_W-spme_pkg::OFS_W){oy[spme_pkg::OFS_W-1]}}, oy});
    fxa = fx1[FX_W-1] ? -fx1 : fx1;
    fya = fy1[FX_W-1] ? -fy1 : fy1;
    q4 = {1'b0, axx3} + {1'b0, ayy3};
    for (int k = 0; k < NSQ; k++) begin
      sq_p[k] = (k == 0) ? (y6 * y6) + spme_pkg::SQ_HALF
                         : (sq[k-1] * sq[k-1]) + spme_pkg::SQ_HALF;
    end
    term_r = {1'b0, sq[NSQ-1]} + spme_pkg::TERM_HALF;
    term = hsq[NSQ-1] ? term_r[31:15] : 17'd0;
  end

  always_ff @(posedge clk) begin
    fx1  <= fx_c;
    fy1  <= fy_c;
    inr2 <= (fx1 > -CAP_F) && (fx1 < CAP_F) && (fy1 > -CAP_F) && (fy1 < CAP_F);
    ax2  <= fxa[19:0];
    ay2  <= fya[19:0];
    inr3 <= inr2;
    axx3 <= ax2 * ax2;
    ayy3 <= ay2 * ay2;
    hit4 <= inr3 && (q4 < spme_pkg::CAP_SQ);
    n4   <= q4[39:11];
    hit5 <= hit4;
    p5   <= n4 * spme_pkg::RECIP9;
    hit6 <= hit5;
    y6   <= spme_pkg::Y_ONE - {6'd0, p5[58:33]};
    for (int k = 0; k < NSQ; k++) begin
      sq[k]  <= sq_p[k][62:31];
      hsq[k] <= (k == 0) ? hit6 : hsq[k-1];
    end
    for (int k = 0; k < DLY; k++) begin
      pxd[k] <= (k == 0) ? px_in : pxd[k-1];
      pyd[k] <= (k == 0) ? py_in : pyd[k-1];
    end
    px_out <= pxd[DLY-1];
    py_out <= pyd[DLY-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLY; k++) begin
        acc_d[k].valid <= 1'b0;
      end
      acc_out.valid <= 1'b0;
    end else begin
      for (int k = 0; k < DLY; k++) begin
        acc_d[k] <= (k == 0) ? acc_in : acc_d[k-1];
      end
      acc_out.valid <= acc_d[DLY-1].valid;
      acc_out.sum   <= acc_d[DLY-1].sum + spme_pkg::SUM_W'(term);
      acc_out.cnt   <= acc_d[DLY-1].cnt + spme_pkg::CNT_W'(hsq[NSQ-1]);
    end
  end

endmodule

[design/spme_outq.sv]
// result queue with credit count and the output register
module spme_outq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  output logic                       space,
  input  spme_pkg::acc_t             push,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [spme_pkg::SUM_W-1:0] model_value,
  output logic [spme_pkg::CNT_W-1:0] spots_in_range
);

  localparam int PTR_W = $clog2(spme_pkg::QDEPTH);
  localparam int CNT_W = $clog2(spme_pkg::QDEPTH + 1);
  localparam int ENT_W = spme_pkg::SUM_W + spme_pkg::CNT_W;

  logic [ENT_W-1:0] mem [spme_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fcount, credits;
  logic load, done;
  logic [spme_pkg::SUM_W-1:0] sat;

  assign done  = out_valid && !out_stall;
  assign load  = (fcount != '0) && (!out_valid || !out_stall);
  assign space = credits != CNT_W'(spme_pkg::QDEPTH);
  assign sat   = (push.sum > spme_pkg::MODEL_MAX) ? spme_pkg::MODEL_MAX : push.sum;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= {sat, push.cnt};
    end
    if (load) begin
      {model_value, spots_in_range} <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fcount    <= '0;
      credits   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fcount  <= fcount + CNT_W'(push.valid) - CNT_W'(load);
      credits <= credits + CNT_W'(take) - CNT_W'(done);
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/spot_pattern_model_eval_unit.sv]
// top level of the spot pattern model evaluator
// Takes one pixel per clock while the input is not stalled and returns the summed
// 16-spot model value and the count of captured spots for it, in order. Each of the
// sixteen spots has its own cell of fifteen pipeline stages (offset, square, divide by
// 18432 through a reciprocal multiply, eight squarings), and the running sum walks down
// the row of cells; a result is presented later than its pass through the cells only
// while earlier results are still waiting in the output queue. The 256-entry output
// queue and its credit count let the input keep flowing while results wait; for lack
// of queue space, items stall only when 256 are in flight. After reset and after every
// register write the input stalls while the setup sequencer derives sine, cosine and
// the sixteen spot offsets on its one shared multiplier.
module spot_pattern_model_eval_unit #(
  parameter int COORD_BITS = spme_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [COORD_BITS-1:0]          pixel_x,
  input  logic [COORD_BITS-1:0]          pixel_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spme_pkg::SUM_W-1:0]     model_value,
  output logic [spme_pkg::CNT_W-1:0]     spots_in_range,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  logic busy, space, take;
  logic signed [spme_pkg::OFS_W-1:0] ox [spme_pkg::N_CELLS];
  logic signed [spme_pkg::OFS_W-1:0] oy [spme_pkg::N_CELLS];
  spme_pkg::acc_t acc_c [spme_pkg::N_CELLS+1];
  logic [COORD_BITS-1:0] px_c [spme_pkg::N_CELLS+1];
  logic [COORD_BITS-1:0] py_c [spme_pkg::N_CELLS+1];

  assign in_stall = rst || busy || !space;
  assign take     = in_valid && !in_stall;

  assign acc_c[0].valid = take;
  assign acc_c[0].sum   = '0;
  assign acc_c[0].cnt   = '0;
  assign px_c[0]        = pixel_x;
  assign py_c[0]        = pixel_y;

  spme_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .ox        (ox),
    .oy        (oy)
  );

  for (genvar g = 0; g < spme_pkg::N_CELLS; g++) begin : g_cell
    spme_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .acc_in  (acc_c[g]),
      .px_in   (px_c[g]),
      .py_in   (py_c[g]),
      .ox      (ox[g]),
      .oy      (oy[g]),
      .acc_out (acc_c[g+1]),
      .px_out  (px_c[g+1]),
      .py_out  (py_c[g+1])
    );
  end

  spme_outq u_outq (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .space          (space),
    .push           (acc_c[spme_pkg::N_CELLS]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .model_value    (model_value),
    .spots_in_range (spots_in_range)
  );

endmodule

[design/spme_checker.sv]
// port-level assertions for the spot pattern model evaluator and their bind
`include "spot_pattern_model_eval_unit_defines.svh"

module spme_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [spme_pkg::SUM_W-1:0] model_value,
  input logic [spme_pkg::CNT_W-1:0] spots_in_range,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  `SPME_ASSERT_IMPL(a_result_range, clk, rst, out_valid, (spots_in_range <= 5'd16) && (model_value <= 21'd1048576), "result beyond sixteen spots")
  `SPME_ASSERT_IMPL(a_zero_when_none, clk, rst, out_valid && (spots_in_range == 5'd0), model_value == 21'd0, "value without captured spots")
  `SPME_ASSERT_NEXT(a_cfg_stalls_input, clk, rst, cfg_valid && cfg_ready, in_stall, "item taken right after a register write")
  `SPME_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(model_value) && $stable(spots_in_range), "stalled result changed")

endmodule

bind spot_pattern_model_eval_unit spme_checker u_spme_checker (.*);

[tb/sv/spot_pattern_model_eval_unit_test.sv]
// self-checking testbench of the spot pattern model evaluator
`timescale 1ns / 1ps

module spot_pattern_model_eval_unit_test;

  localparam int CB = spme_pkg::COORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [spme_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint CAPTURE_AXIS = 786432;
  localparam logic [63:0] KRAD_U = 64'd18740330;
  localparam logic [63:0] C1_U = 64'd1073414225;
  localparam logic [63:0] C3_U = 64'd177886808;
  localparam logic [63:0] C5_U = 64'd8067452;

  typedef struct {
    logic [spme_pkg::SUM_W-1:0] value;
    logic [spme_pkg::CNT_W-1:0] count;
  } model_result_t;

  typedef struct {
    logic [CB-1:0]              px;
    logic [CB-1:0]              py;
    bit                         typed;
    logic [spme_pkg::SUM_W-1:0] value;
    logic [spme_pkg::CNT_W-1:0] count;
  } pixel_row_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [CB-1:0]                  pixel_x;
  logic [CB-1:0]                  pixel_y;
  logic                           out_valid;
  logic                           out_stall;
  logic [spme_pkg::SUM_W-1:0]     model_value;
  logic [spme_pkg::CNT_W-1:0]     spots_in_range;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [spme_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                    cfg_data;

  logic [63:0]   reg_mirror [7];
  longint        spot_x [16];
  longint        spot_y [16];
  model_result_t pending_results [$];
  int            idle_in;
  int            idle_out;
  int            quiet_cycles;
  bit            failed;

  spot_pattern_model_eval_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .model_value(model_value), .spots_in_range(spots_in_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sext32(logic [63:0] v);
    return longint'(signed'(v[31:0]));
  endfunction

  // sine in Q2.30 of an angle in degrees Q16.16
  function automatic longint poly_sine(longint a);
    longint r;
    bit neg;
    logic [63:0] m, x, x2, x3, x5;
    longint s;
    r = a % longint'(spme_pkg::DEG360);
    if (r < 0) r += longint'(spme_pkg::DEG360);
    if (r >= longint'(spme_pkg::DEG180)) r -= longint'(spme_pkg::DEG360);
    if (r > longint'(spme_pkg::DEG90)) r = longint'(spme_pkg::DEG180) - r;
    if (r < -longint'(spme_pkg::DEG90)) r = -longint'(spme_pkg::DEG180) - r;
    neg = r < 0;
    m = neg ? -r : r;
    x = (m * KRAD_U) >> 16;
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x5 = (x3 * x2) >> 30;
    s = longint'((C1_U * x) >> 30) - longint'((C3_U * x3) >> 30)
        + longint'((C5_U * x5) >> 30);
    return neg ? -s : s;
  endfunction

  function automatic void update_geometry();
    longint xs [4], ys [4], xd [4], yd [4];
    longint ang, sx, sy, s, c, a, b, e, d;
    longint t [4], u [4];
    t[0] = sext32(reg_mirror[spme_pkg::REG_X_LO]);
    t[1] = sext32(reg_mirror[spme_pkg::REG_X_LO] >> 32);
    t[2] = sext32(reg_mirror[spme_pkg::REG_X_HI]);
    t[3] = sext32(reg_mirror[spme_pkg::REG_X_HI] >> 32);
    u[0] = sext32(reg_mirror[spme_pkg::REG_Y_LO]);
    u[1] = sext32(reg_mirror[spme_pkg::REG_Y_LO] >> 32);
    u[2] = sext32(reg_mirror[spme_pkg::REG_Y_HI]);
    u[3] = sext32(reg_mirror[spme_pkg::REG_Y_HI] >> 32);
    xs[0] = t[0] + t[1] + t[2] + t[3]; xs[1] = t[0] - t[1] + t[2] - t[3];
    xs[2] = t[0] + t[1] - t[2] - t[3]; xs[3] = t[0] - t[1] - t[2] + t[3];
    ys[0] = u[0] + u[1] + u[2] + u[3]; ys[1] = u[0] - u[1] + u[2] - u[3];
    ys[2] = u[0] + u[1] - u[2] - u[3]; ys[3] = u[0] - u[1] - u[2] + u[3];
    ang = sext32(reg_mirror[spme_pkg::REG_ANGLE]);
    sx = sext32(reg_mirror[spme_pkg::REG_STEP_X]);
    sy = sext32(reg_mirror[spme_pkg::REG_STEP_Y]);
    s = poly_sine(ang);
    c = poly_sine(ang + longint'(spme_pkg::DEG90));
    a = c * sx; b = s * sy; e = c * sy; d = s * sx;
    xd[0] = (-a + b) >>> 31; xd[1] = (-a - b) >>> 31;
    xd[2] = (a - b) >>> 31;  xd[3] = (a + b) >>> 31;
    yd[0] = (e + d) >>> 31;  yd[1] = (-e + d) >>> 31;
    yd[2] = (-e - d) >>> 31; yd[3] = (e - d) >>> 31;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        spot_x[4*i+j] = xs[j] + xd[i];
        spot_y[4*i+j] = ys[j] + yd[i];
      end
    end
  endfunction

  function automatic model_result_t spot_model_at(logic [CB-1:0] px, logic [CB-1:0] py);
    model_result_t res;
    longint fx, fy;
    logic [63:0] ax, ay, q, y;
    int unsigned total, hits;
    total = 0;
    hits = 0;
    for (int k = 0; k < 16; k++) begin
      fx = (longint'(px) << 16) - spot_x[k];
      fy = (longint'(py) << 16) - spot_y[k];
      if (fx > -CAPTURE_AXIS && fx < CAPTURE_AXIS && fy > -CAPTURE_AXIS
          && fy < CAPTURE_AXIS) begin
        ax = fx < 0 ? -fx : fx;
        ay = fy < 0 ? -fy : fy;
        q = ax * ax + ay * ay;
        if (q < 64'(spme_pkg::CAP_SQ)) begin
          y = 64'h8000_0000 - q / 64'd18432;
          for (int n = 0; n < 8; n++) y = (y * y + 64'h4000_0000) >> 31;
          total += int'((y + 64'h4000) >> 15);
          hits++;
        end
      end
    end
    if (total > spme_pkg::MODEL_MAX) total = spme_pkg::MODEL_MAX;
    res.value = total[spme_pkg::SUM_W-1:0];
    res.count = hits[spme_pkg::CNT_W-1:0];
    return res;
  endfunction

  task automatic write_register(logic [spme_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < REG_UNUSED) begin
      reg_mirror[idx] = (idx <= spme_pkg::REG_Y_HI) ? data : {32'd0, data[31:0]};
    end
    update_geometry();
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(logic [CB-1:0] px, logic [CB-1:0] py, bit typed,
                            model_result_t typed_res);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    pending_results.push_back(typed ? typed_res : spot_model_at(px, py));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] near_coord(longint centre);
    longint p;
    p = (centre >>> 16) + longint'($urandom_range(26)) - 13;
    if (p < 0 || p > 4095) p = $urandom_range(4095);
    return p[CB-1:0];
  endfunction

  task automatic random_setup(int flavour);
    logic [31:0] t [4];
    for (int k = 0; k < 4; k++) begin
      t[k] = (k == 0) ? ($urandom_range(3600, 200) << 16) + $urandom_range(65535)
                      : 32'(($urandom_range(80) - 40) * 65536 + $urandom_range(65535));
    end
    write_register(spme_pkg::REG_X_LO, {t[1], t[0]});
    write_register(spme_pkg::REG_X_HI, {t[3], t[2]});
    t[0] = ($urandom_range(3600, 200) << 16) + $urandom_range(65535);
    write_register(spme_pkg::REG_Y_LO, {t[1] ^ 32'h0003_ffff, t[0]});
    write_register(spme_pkg::REG_Y_HI, {t[2], t[3]});
    case (flavour)
      0: begin
        write_register(spme_pkg::REG_ANGLE, {$urandom, 32'h8000_0000});
        write_register(spme_pkg::REG_STEP_X, {$urandom, 32'h7fff_ffff});
        write_register(spme_pkg::REG_STEP_Y, {$urandom, 32'h8000_0000});
      end
      1: begin
        write_register(spme_pkg::REG_ANGLE, {$urandom, 32'h7fff_ffff});
        write_register(spme_pkg::REG_STEP_X, 64'd0);
        write_register(spme_pkg::REG_STEP_Y, 64'd0);
      end
      default: begin
        write_register(spme_pkg::REG_ANGLE, {$urandom, $urandom});
        write_register(spme_pkg::REG_STEP_X, {$urandom, 32'(($urandom_range(60) - 30) * 65536
                                                  + $urandom_range(65535))});
        write_register(spme_pkg::REG_STEP_Y, {$urandom, 32'(($urandom_range(60) - 30) * 65536
                                                  + $urandom_range(65535))});
      end
    endcase
    write_register(REG_UNUSED, {$urandom, $urandom});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < idle_out);
    end
  end

  always @(posedge clk) begin
    model_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: model_value %0d spots_in_range %0d",
               model_value, spots_in_range);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (model_value !== want.value) begin
          $error("model_value expected %0d actual %0d", want.value, model_value);
          failed = 1'b1;
        end
        if (spots_in_range !== want.count) begin
          $error("spots_in_range expected %0d actual %0d", want.count, spots_in_range);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("spot_pattern_model_eval_unit_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pixel_row_t rows [$];
    model_result_t r;
    int k;
    failed = 1'b0;
    quiet_cycles = 0;
    idle_in = 35;
    idle_out = 49;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel_x = '0;
    pixel_y = '0;
    cfg_valid = 1'b0;
    cfg_index = spme_pkg::REG_X_LO;
    cfg_data = '0;
    reg_mirror[spme_pkg::REG_X_LO] = '0; reg_mirror[spme_pkg::REG_X_HI] = '0;
    reg_mirror[spme_pkg::REG_Y_LO] = '0; reg_mirror[spme_pkg::REG_Y_HI] = '0;
    reg_mirror[spme_pkg::REG_ANGLE] = '0;
    reg_mirror[spme_pkg::REG_STEP_X] = 64'(spme_pkg::STEP_X_RST);
    reg_mirror[spme_pkg::REG_STEP_Y] = 64'(spme_pkg::STEP_Y_RST);
    update_geometry();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // after reset: spots around the origin, far corner empty
    rows = '{'{12'd4095, 12'd4095, 1, 21'd0, 5'd0},
             '{12'd0, 12'd0, 0, 21'd0, 5'd0},
             '{12'd9, 12'd12, 0, 21'd0, 5'd0},
             '{12'd0, 12'd4095, 0, 21'd0, 5'd0},
             '{12'd20, 12'd3, 0, 21'd0, 5'd0}};
    foreach (rows[n]) begin
      r.value = rows[n].value;
      r.count = rows[n].count;
      send_pixel(rows[n].px, rows[n].py, rows[n].typed, r);
    end
    in_valid <= 1'b0;
    wait_idle();

    // all sixteen spots stacked on the origin: saturated sum
    write_register(spme_pkg::REG_STEP_X, {32'hffff_ffff, 32'd0});
    write_register(spme_pkg::REG_STEP_Y, 64'd0);
    rows = '{'{12'd0, 12'd0, 1, 21'd1048576, 5'd16},
             '{12'd4095, 12'd0, 1, 21'd0, 5'd0},
             '{12'd0, 12'd4095, 1, 21'd0, 5'd0},
             '{12'd11, 12'd0, 0, 21'd0, 5'd0},
             '{12'd12, 12'd0, 1, 21'd0, 5'd0},
             '{12'd8, 12'd8, 0, 21'd0, 5'd0},
             '{12'd1, 12'd1, 0, 21'd0, 5'd0}};
    foreach (rows[n]) begin
      r.value = rows[n].value;
      r.count = rows[n].count;
      send_pixel(rows[n].px, rows[n].py, rows[n].typed, r);
    end
    in_valid <= 1'b0;
    wait_idle();

    // terms at their extremes, angle at both ends
    write_register(spme_pkg::REG_X_LO, 64'h8000_0000_7fff_ffff);
    write_register(spme_pkg::REG_X_HI, 64'h7fff_ffff_8000_0000);
    write_register(spme_pkg::REG_Y_LO, 64'hffff_ffff_ffff_ffff);
    write_register(spme_pkg::REG_Y_HI, 64'h0000_0000_0000_0000);
    write_register(spme_pkg::REG_ANGLE, 64'h0000_0000_8000_0000);
    write_register(spme_pkg::REG_STEP_X, 64'h0000_0000_7fff_ffff);
    write_register(spme_pkg::REG_STEP_Y, 64'h0000_0000_8000_0000);
    write_register(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    send_pixel(12'd0, 12'd0, 0, r);
    send_pixel(12'd4095, 12'd4095, 0, r);
    in_valid <= 1'b0;
    wait_idle();
    write_register(spme_pkg::REG_ANGLE, 64'hffff_ffff_7fff_ffff);
    send_pixel(12'd2048, 12'd1, 0, r);
    send_pixel(12'd1, 12'd2048, 0, r);
    in_valid <= 1'b0;
    wait_idle();

    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        idle_in = 49;
        idle_out = 35;
      end else if (phase == 6) begin
        idle_in = 0;
        idle_out = 0;
      end
      random_setup(phase % 4);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(99) < 80) begin
          k = $urandom_range(15);
          send_pixel(near_coord(spot_x[k]), near_coord(spot_y[k]), 0, r);
        end else begin
          send_pixel(CB'($urandom), CB'($urandom), 0, r);
        end
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (!failed) begin
      $display("spot_pattern_model_eval_unit_test: PASS");
    end else begin
      $display("spot_pattern_model_eval_unit_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/spme_pkg.sv
design/spme_setup.sv
design/spme_cell.sv
design/spme_outq.sv
design/spot_pattern_model_eval_unit.sv
design/spme_checker.sv
tb/sv/spot_pattern_model_eval_unit_test.sv
